// ----- hw/rtl/kdslp_pkg.sv -----
package kdslp_pkg;

   // configuration space
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // counter widths
   localparam int unsigned HOLD_W = 7;
   localparam int unsigned REL_W  = 3;

   // register reset values
   localparam logic [HOLD_W-1:0] SHORT_TICKS_RST   = 7'd8;
   localparam logic [HOLD_W-1:0] LONG_TICKS_RST    = 7'd100;
   localparam logic [REL_W-1:0]  RELEASE_TICKS_RST = 3'd5;

   // counter ceilings
   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;
   localparam logic [REL_W-1:0]  REL_MAX  = '1;

   // register index, taken from paddr word bits
   typedef enum logic [1:0] {
      REG_SHORT_TICKS   = 2'd0,
      REG_LONG_TICKS    = 2'd1,
      REG_RELEASE_TICKS = 2'd2,
      REG_IDLE_VALUE    = 2'd3
   } reg_idx_type;

endpackage

// ----- hw/rtl/kdslp_req_if.sv -----
interface kdslp_req_if #(
   parameter int unsigned NUM_KEYS = 6
);
   logic                valid;
   logic                ready;
   logic [NUM_KEYS-1:0] raw_keys;

   modport source (output valid, output raw_keys, input ready);
   modport sink (input valid, input raw_keys, output ready);
endinterface

// ----- hw/rtl/kdslp_rsp_if.sv -----
interface kdslp_rsp_if #(
   parameter int unsigned NUM_KEYS = 6,
   parameter int unsigned KEY_W    = $clog2(NUM_KEYS + 1)
);
   logic                valid;
   logic                ready;
   logic [NUM_KEYS-1:0] held_pattern;
   logic                short_held;
   logic                long_held;
   logic                release_event;
   logic [KEY_W-1:0]    event_key;

   modport source (
      output valid, output held_pattern, output short_held, output long_held,
      output release_event, output event_key, input ready
   );
   modport sink (
      input valid, input held_pattern, input short_held, input long_held,
      input release_event, input event_key, output ready
   );
endinterface

// ----- hw/rtl/key_debounce_short_long_press.sv -----
// Key debouncer with short and long press detection. Each req beat is one scan
// tick of NUM_KEYS active-low pins; each tick gives exactly one rsp beat holding
// the latched pattern, the short and long flags after the tick, and a one-tick
// release event naming the key (NUM_KEYS when the latched pattern is not a single
// key or there is no event). Throughput is one tick per clock while the skid entry is
// empty: the whole tick update is one pass of compare and counter logic from the state
// registers into the output register, or into the skid register while the output waits.
// A two-entry output buffer lets a new tick be taken while one result waits on a
// stalled rsp side. Thresholds and the idle pattern are set over the APB port; the user
// must write them only while the block is idle, as the block itself does not enforce it.
module key_debounce_short_long_press
   import kdslp_pkg::*;
#(
   parameter int unsigned NUM_KEYS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   kdslp_req_if.sink             req_bus,
   kdslp_rsp_if.source           rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int unsigned KEY_W = $clog2(NUM_KEYS + 1);
   localparam int unsigned RES_W = NUM_KEYS + 3 + KEY_W;
   localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(NUM_KEYS);

   // configuration registers
   logic [HOLD_W-1:0]   short_ticks_ff, short_ticks_in;
   logic [HOLD_W-1:0]   long_ticks_ff, long_ticks_in;
   logic [REL_W-1:0]    release_ticks_ff, release_ticks_in;
   logic [NUM_KEYS-1:0] idle_value_ff, idle_value_in;

   // scan state
   logic [NUM_KEYS-1:0] last_pattern_ff, last_pattern_in;
   logic [HOLD_W-1:0]   hold_count_ff, hold_count_in;
   logic [REL_W-1:0]    release_count_ff, release_count_in;
   logic                short_flag_ff, short_flag_in;
   logic                long_flag_ff, long_flag_in;
   logic [NUM_KEYS-1:0] latched_ff, latched_in;

   // output buffer
   logic             out_valid_ff, out_valid_in;
   logic [RES_W-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [RES_W-1:0] skid_data_ff, skid_data_in;

   logic             csr_wr;
   reg_idx_type      csr_idx;
   logic             req_take;
   logic [NUM_KEYS-1:0] pat;
   logic [HOLD_W-1:0]   hold_next;
   logic [REL_W-1:0]    rel_sat;
   logic                ev;
   logic [KEY_W-1:0]    key;
   logic [RES_W-1:0]    result;

   // apb access
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = reg_idx_type'(paddr[3:2]);

   always_comb begin
      short_ticks_in   = short_ticks_ff;
      long_ticks_in    = long_ticks_ff;
      release_ticks_in = release_ticks_ff;
      idle_value_in    = idle_value_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_SHORT_TICKS:   short_ticks_in   = pwdata[HOLD_W-1:0];
            REG_LONG_TICKS:    long_ticks_in    = pwdata[HOLD_W-1:0];
            REG_RELEASE_TICKS: release_ticks_in = pwdata[REL_W-1:0];
            REG_IDLE_VALUE:    idle_value_in    = pwdata[NUM_KEYS-1:0];
         endcase
      end
   end

   // register readback
   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         REG_SHORT_TICKS:   prdata[HOLD_W-1:0]   = short_ticks_ff;
         REG_LONG_TICKS:    prdata[HOLD_W-1:0]   = long_ticks_ff;
         REG_RELEASE_TICKS: prdata[REL_W-1:0]    = release_ticks_ff;
         REG_IDLE_VALUE:    prdata[NUM_KEYS-1:0] = idle_value_ff;
      endcase
   end

   // tick update
   assign req_bus.ready = !skid_valid_ff;
   assign req_take      = req_bus.valid && !skid_valid_ff;
   assign pat           = ~req_bus.raw_keys;
   assign rel_sat       = (release_count_ff == REL_MAX) ? REL_MAX : release_count_ff + 1'b1;

   always_comb begin
      hold_next = hold_count_ff;
      if (hold_count_ff >= short_ticks_ff && hold_count_ff >= long_ticks_ff) begin
         hold_next = long_ticks_ff;
      end
   end

   always_comb begin
      last_pattern_in  = last_pattern_ff;
      hold_count_in    = hold_count_ff;
      release_count_in = release_count_ff;
      short_flag_in    = short_flag_ff;
      long_flag_in     = long_flag_ff;
      latched_in       = latched_ff;
      ev               = 1'b0;
      key              = NO_KEY;
      if (req_take) begin
         last_pattern_in = pat;
         if (last_pattern_ff == pat) begin
            if (pat != idle_value_ff) begin
               release_count_in = '0;
               // hold_next is long_ticks once both thresholds are met
               hold_count_in = (hold_next == HOLD_MAX) ? HOLD_MAX : hold_next + 1'b1;
               if (hold_count_ff >= short_ticks_ff) begin
                  latched_in    = pat;
                  short_flag_in = 1'b1;
                  if (hold_count_ff >= long_ticks_ff) begin
                     short_flag_in = 1'b0;
                     long_flag_in  = 1'b1;
                  end
               end
            end else begin
               hold_count_in = '0;
               if (rel_sat >= release_ticks_ff) begin
                  release_count_in = '0;
                  short_flag_in    = 1'b0;
                  long_flag_in     = 1'b0;
               end else begin
                  release_count_in = rel_sat;
               end
            end
         end else begin
            hold_count_in    = '0;
            release_count_in = '0;
         end
         // end of a short press
         if (short_flag_in && hold_count_in == '0) begin
            ev            = 1'b1;
            short_flag_in = 1'b0;
            for (int i = 0; i < NUM_KEYS; i++) begin
               if (latched_in == (NUM_KEYS'(1) << i)) begin
                  key = KEY_W'(i);
               end
            end
         end
      end
   end

   assign result = {latched_in, short_flag_in, long_flag_in, ev, key};

   // output buffer: main stage plus skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_take;
            out_data_in  = result;
         end
      end else if (req_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign {rsp_bus.held_pattern, rsp_bus.short_held, rsp_bus.long_held,
           rsp_bus.release_event, rsp_bus.event_key} = out_data_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ticks_ff   <= SHORT_TICKS_RST;
         long_ticks_ff    <= LONG_TICKS_RST;
         release_ticks_ff <= RELEASE_TICKS_RST;
         idle_value_ff    <= '0;
         last_pattern_ff  <= '0;
         hold_count_ff    <= '0;
         release_count_ff <= '0;
         short_flag_ff    <= 1'b0;
         long_flag_ff     <= 1'b0;
         latched_ff       <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         short_ticks_ff   <= short_ticks_in;
         long_ticks_ff    <= long_ticks_in;
         release_ticks_ff <= release_ticks_in;
         idle_value_ff    <= idle_value_in;
         last_pattern_ff  <= last_pattern_in;
         hold_count_ff    <= hold_count_in;
         release_count_ff <= release_count_in;
         short_flag_ff    <= short_flag_in;
         long_flag_ff     <= long_flag_in;
         latched_ff       <= latched_in;
         out_valid_ff     <= out_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTH
   // skid holds a beat only behind a waiting main stage
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid valid with empty output stage");

   // no event means no key index
   a_key_without_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.release_event) |-> (rsp_bus.event_key == NO_KEY))
      else $error("key index without release event");

   // a release event always clears the short flag
   a_event_clears_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.release_event) |-> !rsp_bus.short_held)
      else $error("short flag still set on release event");

   // a tick with the previous pattern changed restarts the hold count
   a_change_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (req_take && (pat != last_pattern_ff)) |=> (hold_count_ff == '0))
      else $error("hold count not cleared on pattern change");
`endif

endmodule

// ----- tb/sv/press_state_checker.sv -----
module press_state_checker
   import kdslp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   kdslp_req_if                  req_bus,
   kdslp_rsp_if                  rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output int unsigned           mismatches,
   output int unsigned           ticks_open
);

   localparam int unsigned KEYS = 6;
   localparam logic [2:0] NO_KEY = 3'(KEYS);

   typedef struct packed {
      logic [KEYS-1:0] pattern;
      logic            short_f;
      logic            long_f;
      logic            rel_ev;
      logic [2:0]      key;
   } press_state_type;

   // register copies
   logic [HOLD_W-1:0] short_lim;
   logic [HOLD_W-1:0] long_lim;
   logic [REL_W-1:0]  rel_lim;
   logic [KEYS-1:0]   idle_pat;

   // scan state
   logic [KEYS-1:0]   last_pat;
   logic [HOLD_W-1:0] hold_cnt;
   logic [REL_W-1:0]  rel_cnt;
   logic              short_f;
   logic              long_f;
   logic [KEYS-1:0]   latch_pat;

   press_state_type press_states[$];

   function automatic logic [HOLD_W-1:0] bump_hold(input logic [HOLD_W-1:0] h);
      return (h == HOLD_MAX) ? HOLD_MAX : h + 1'b1;
   endfunction

   function automatic logic [2:0] key_index(input logic [KEYS-1:0] p);
      logic [2:0] k;
      k = NO_KEY;
      for (int i = 0; i < KEYS; i++) begin
         if (p == (KEYS'(1) << i)) k = 3'(i);
      end
      return k;
   endfunction

   // one scan tick: debounce, hold and release counting, then the release event
   function automatic press_state_type scan_tick(input logic [KEYS-1:0] raw);
      press_state_type r;
      logic [KEYS-1:0] pat;
      logic [KEYS-1:0] prev;
      pat = ~raw;
      prev = last_pat;
      last_pat = pat;
      r.rel_ev = 1'b0;
      r.key = NO_KEY;
      if (prev == pat) begin
         if (pat != idle_pat) begin
            rel_cnt = '0;
            if (hold_cnt >= short_lim) begin
               latch_pat = pat;
               short_f = 1'b1;
               if (hold_cnt >= long_lim) begin
                  short_f = 1'b0;
                  long_f = 1'b1;
                  hold_cnt = bump_hold(long_lim);
               end else begin
                  hold_cnt = bump_hold(hold_cnt);
               end
            end else begin
               hold_cnt = bump_hold(hold_cnt);
            end
         end else begin
            hold_cnt = '0;
            if (rel_cnt != REL_MAX) rel_cnt = rel_cnt + 1'b1;
            if (rel_cnt >= rel_lim) begin
               rel_cnt = '0;
               short_f = 1'b0;
               long_f = 1'b0;
            end
         end
      end else begin
         hold_cnt = '0;
         rel_cnt = '0;
      end
      // short press ended
      if (short_f && hold_cnt == '0) begin
         r.rel_ev = 1'b1;
         r.key = key_index(latch_pat);
         short_f = 1'b0;
      end
      r.pattern = latch_pat;
      r.short_f = short_f;
      r.long_f = long_f;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches = mismatches + 1;
      end
   endtask

   initial begin
      mismatches = 0;
      ticks_open = 0;
   end

   // sample between edges: values are settled for the coming rising edge
   always @(negedge clock) begin
      press_state_type got;
      press_state_type want;
      if (reset) begin
         short_lim = SHORT_TICKS_RST;
         long_lim = LONG_TICKS_RST;
         rel_lim = RELEASE_TICKS_RST;
         idle_pat = '0;
         last_pat = '0;
         hold_cnt = '0;
         rel_cnt = '0;
         short_f = 1'b0;
         long_f = 1'b0;
         latch_pat = '0;
         press_states.delete();
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (reg_idx_type'(paddr[3:2]))
               REG_SHORT_TICKS:   short_lim = pwdata[HOLD_W-1:0];
               REG_LONG_TICKS:    long_lim = pwdata[HOLD_W-1:0];
               REG_RELEASE_TICKS: rel_lim = pwdata[REL_W-1:0];
               REG_IDLE_VALUE:    idle_pat = pwdata[KEYS-1:0];
               default: ;
            endcase
         end
         // result beat against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.pattern = rsp_bus.held_pattern;
            got.short_f = rsp_bus.short_held;
            got.long_f = rsp_bus.long_held;
            got.rel_ev = rsp_bus.release_event;
            got.key = rsp_bus.event_key;
            if (press_states.size() == 0) begin
               $display("%0t: result beat with nothing expected, expected none, actual %h",
                        $time, got);
               mismatches = mismatches + 1;
            end else begin
               want = press_states.pop_front();
               check_field("held_pattern", want.pattern, got.pattern);
               check_field("short_held", want.short_f, got.short_f);
               check_field("long_held", want.long_f, got.long_f);
               check_field("release_event", want.rel_ev, got.rel_ev);
               check_field("event_key", want.key, got.key);
            end
         end
         // scan tick beat
         if (req_bus.valid && req_bus.ready)
            press_states.push_back(scan_tick(req_bus.raw_keys));
      end
      ticks_open = press_states.size();
   end

endmodule

// ----- tb/sv/key_debounce_short_long_press_test.sv -----
module key_debounce_short_long_press_test;
   import kdslp_pkg::*;

   localparam int unsigned KEYS = 6;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned LONG_HOLD_OFF = 60;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int unsigned           mismatches;
   int unsigned           ticks_open;

   // stimulus controls
   logic                  quiet;
   int unsigned           stall_asks;
   int unsigned           ticks_sent;

   // register copies for shaping press lengths
   logic [HOLD_W-1:0]     short_lim;
   logic [HOLD_W-1:0]     long_lim;
   logic [REL_W-1:0]      rel_lim;
   logic [KEYS-1:0]       idle_pat;

   kdslp_req_if #(.NUM_KEYS(KEYS)) req_bus ();
   kdslp_rsp_if #(.NUM_KEYS(KEYS)) rsp_bus ();

   key_debounce_short_long_press #(.NUM_KEYS(KEYS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   press_state_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .ticks_open (ticks_open)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #(CYCLE_LIMIT * 4);
      $display("TEST FAILED");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int unsigned stalls_done;
      stalls_done = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (stall_asks != stalls_done) begin
            stalls_done++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_OFF) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // one scan tick beat, with an occasional gap ahead of it
   task automatic send_tick(input logic [KEYS-1:0] raw);
      logic took;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.raw_keys <= raw;
      do begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end while (!took);
      ticks_sent++;
   endtask

   // apb write: setup then access, then idle
   task automatic csr_write(input reg_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // drain all outstanding results with the input held off
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (ticks_open != 0) @(posedge clock);
   endtask

   // a held pattern, an idle stretch or a burst of glitches
   task automatic play_segment();
      logic [KEYS-1:0] pat;
      int unsigned len;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: pat = KEYS'(1) << $urandom_range(0, KEYS - 1);
         5, 6: pat = KEYS'($urandom);
         7, 8: pat = idle_pat;
         default: begin
            repeat ($urandom_range(1, 4)) send_tick(KEYS'($urandom));
            return;
         end
      endcase
      case ($urandom_range(0, 4))
         0: len = $urandom_range(1, 3);
         1: len = $urandom_range(short_lim, short_lim + 3);
         2: len = $urandom_range(long_lim, long_lim + 3);
         3: len = $urandom_range(1, rel_lim + 3);
         default: len = $urandom_range(1, 24);
      endcase
      repeat (len) send_tick(~pat);
   endtask

   task automatic run_phase(input logic [HOLD_W-1:0] s, input logic [HOLD_W-1:0] l,
                            input logic [REL_W-1:0] r, input logic [KEYS-1:0] idle,
                            input int unsigned quota);
      int unsigned target;
      settle();
      csr_write(REG_SHORT_TICKS, CSR_DATA_W'(s));
      csr_write(REG_LONG_TICKS, CSR_DATA_W'(l));
      csr_write(REG_RELEASE_TICKS, CSR_DATA_W'(r));
      csr_write(REG_IDLE_VALUE, CSR_DATA_W'(idle));
      short_lim = s;
      long_lim = l;
      rel_lim = r;
      idle_pat = idle;
      target = ticks_sent + quota;
      while (ticks_sent < target) play_segment();
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.raw_keys <= '1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      quiet <= 1'b0;
      stall_asks <= 0;
      ticks_sent = 0;
      short_lim = SHORT_TICKS_RST;
      long_lim = LONG_TICKS_RST;
      rel_lim = RELEASE_TICKS_RST;
      idle_pat = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: idle, all keys glitch, short press of key 0 then key 5
      repeat (3) send_tick(6'h3F);
      send_tick(6'h00);
      send_tick(6'h3F);
      repeat (10) send_tick(6'h3E);
      repeat (10) send_tick(6'h1F);
      send_tick(6'h00);

      // reset settings
      while (ticks_sent < 120) play_segment();

      // fast thresholds, result side held off for a long stretch
      settle();
      stall_asks <= stall_asks + 1;
      run_phase(7'd2, 7'd6, 3'd1, 6'h00, 90);

      // thresholds near the top, all keys pressed is idle
      run_phase(7'd125, 7'd126, 3'd7, 6'h3F, 110);

      // short threshold above long
      run_phase(7'd5, 7'd3, 3'd3, KEYS'($urandom), 60);

      // zero short and release thresholds, long threshold at the hold counter top
      run_phase(7'd0, 7'd127, 3'd0, 6'h15, 110);

      // random settings, no idling to the end
      settle();
      quiet <= 1'b1;
      run_phase(HOLD_W'($urandom_range(1, 12)), HOLD_W'($urandom_range(2, 20)),
                REL_W'($urandom_range(1, 7)), KEYS'($urandom), 60);

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
